[rtl/bnc_pkg.sv]
// Shared types and constants for the binary 3x3 neighbor count block.
package bnc_pkg;

  localparam int unsigned PIX_W          = 8;
  localparam int unsigned CFG_W          = 11;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Pixel value that marks foreground.
  localparam logic [PIX_W-1:0] FG_VALUE = 8'd1;

  // One line memory entry: a pixel and the foreground flag of the row above it.
  typedef struct packed {
    logic             prev_fg;
    logic [PIX_W-1:0] value;
  } line_ent_t;

  // One window column: flag above, full center-row value, flag below.
  typedef struct packed {
    logic             top;
    logic [PIX_W-1:0] mid;
    logic             bot;
  } wcol_t;

  // Which neighbor rows and columns lie inside the image.
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } nbr_mask_t;

  // One result request.
  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] value;
  } res_t;

endpackage

[rtl/bnc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bnc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/bnc_window.sv]
// 3x3 window registers and the masked neighbor count for the center pixel.
module bnc_window (
  input  logic                    clk_i,
  input  logic                    shift_i,
  input  bnc_pkg::wcol_t          ncol_i,
  input  bnc_pkg::nbr_mask_t      mask_i,
  output logic [bnc_pkg::PIX_W-1:0] value_o
);
  import bnc_pkg::*;

  // Left column keeps flags only; the center column keeps the full center value.
  logic [2:0]       left_q;
  wcol_t            ctr_q;
  logic [CNT_W-1:0] cnt;
  logic             ctr_fg;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      left_q <= {ctr_q.top, (ctr_q.mid == FG_VALUE), ctr_q.bot};
      ctr_q  <= ncol_i;
    end
  end

  always_comb begin
    ctr_fg = (ctr_q.mid == FG_VALUE);
    cnt = CNT_W'(left_q[2] & mask_i.top & mask_i.left)
        + CNT_W'(left_q[1] & mask_i.left)
        + CNT_W'(left_q[0] & mask_i.bot & mask_i.left)
        + CNT_W'(ctr_q.top & mask_i.top)
        + CNT_W'(ctr_q.bot & mask_i.bot)
        + CNT_W'(ncol_i.top & mask_i.top & mask_i.right)
        + CNT_W'((ncol_i.mid == FG_VALUE) & mask_i.right)
        + CNT_W'(ncol_i.bot & mask_i.bot & mask_i.right);
    if (ctr_fg && (cnt != '0)) begin
      value_o = PIX_W'(cnt);
    end else begin
      value_o = ctr_q.mid;
    end
  end

endmodule

[rtl/bnc_out_buf.sv]
// Two-entry result buffer between the window logic and the output stream.
module bnc_out_buf (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  bnc_pkg::res_t                  push_data_i,
  output logic                           full_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bnc_pkg::PIX_W-1:0]      m_axis_tdata,
  output logic                           m_axis_tlast
);
  import bnc_pkg::*;

  res_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = slot_q[rd_ptr_q].value;
  assign m_axis_tlast  = slot_q[rd_ptr_q].last;
  assign full_o        = (cnt_q == 2'd2);
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/binary_neighbor_count_3x3_top.sv]
// Top level of the binary 3x3 neighbor count block.
//
// Usage: pixels enter in raster order on the slave stream, one request per
// pixel, with tuser low. For every pixel equal to 1 the block counts its
// foreground 8-neighbors that lie inside the image; a nonzero count replaces
// the pixel on the master stream, otherwise the pixel passes unchanged.
// Results leave in raster order, image_width+1 requests behind the input.
// After the last pixel of a frame, drain requests (tuser high) flush the
// remaining image_width+1 results, one per request; tlast marks the result
// of the frame's final pixel, after which the next pixel starts a new frame.
// Throughput is one request per cycle while the output buffer has room. Each
// result is registered in the output buffer. The line memory is read one
// column ahead of the input, so each request finds its column waiting and
// writes its own column back in the same cycle.
// A two-entry output buffer lets the input keep flowing while one result
// waits; when it holds two results, tready drops until the receiver takes one.
// Reset clears all counters and sets both dimensions to 2; the line memory
// needs no clearing pass. A width or height write restarts the stream.
module binary_neighbor_count_3x3_top #(
  parameter int unsigned MAX_WIDTH  = bnc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bnc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [bnc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bnc_pkg::CFG_W-1:0]       cfg_wdata_i,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bnc_pkg::PIX_W-1:0]       s_axis_tdata,  // [7:0] pixel_value
  input  logic                            s_axis_tuser,  // [0] req_type
  // Output stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bnc_pkg::PIX_W-1:0]       m_axis_tdata,  // [7:0] out_value
  output logic                            m_axis_tlast   // last_of_frame
);
  import bnc_pkg::*;

  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned DimW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DimHW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PendW = $clog2(MAX_WIDTH + 2);

  // Dimensions after clamping.
  logic [DimW-1:0]  width_q, width_d;
  logic [DimHW-1:0] height_q, height_d;

  // Input position; during draining the column keeps walking the last row.
  logic [ColW-1:0]  in_col_q, in_col_d;
  logic [DimHW-1:0] in_row_q, in_row_d;
  // Position of the next result.
  logic [ColW-1:0]  out_col_q, out_col_d;
  logic [DimHW-1:0] out_row_q, out_row_d;
  logic [PendW-1:0] pending_q, pending_d;

  logic        accept, req_drain, frame_in, pend_full;
  logic        pix_step, drn_step, step, emit, restart, cfg_hit;
  logic        in_col_last, out_col_last, out_row_last, out_last;
  logic        buf_full;
  logic [31:0] cfg_ext, width_cl, height_cl;

  line_ent_t   rd_ent, wr_ent;
  wcol_t       ncol;
  nbr_mask_t   mask;
  res_t        res;

  assign s_axis_tready = !buf_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req_drain     = (s_axis_tuser == REQ_DRAIN);
  assign frame_in      = (in_row_q >= height_q);
  assign pend_full     = ((DimW+1)'(pending_q) == ((DimW+1)'(width_q) + (DimW+1)'(1)));

  assign pix_step = accept && !req_drain && !frame_in;
  assign drn_step = accept && req_drain && frame_in && (pending_q != '0);
  assign step     = pix_step || drn_step;
  assign emit     = drn_step || (pix_step && pend_full);

  assign in_col_last  = (DimW'(in_col_q) == (width_q - DimW'(1)));
  assign out_col_last = (DimW'(out_col_q) == (width_q - DimW'(1)));
  assign out_row_last = (out_row_q == (height_q - DimHW'(1)));
  assign out_last     = out_col_last && out_row_last;

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == CFG_IDX_WIDTH) || (cfg_idx_i == CFG_IDX_HEIGHT));
  assign restart = cfg_hit || (emit && out_last);

  // Clamp a written dimension into its legal range.
  always_comb begin
    cfg_ext = 32'(cfg_wdata_i);
    if (cfg_ext < 32'd2) begin
      width_cl  = 32'd2;
      height_cl = 32'd2;
    end else begin
      width_cl  = (cfg_ext > 32'(MAX_WIDTH))  ? 32'(MAX_WIDTH)  : cfg_ext;
      height_cl = (cfg_ext > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : cfg_ext;
    end
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i && (cfg_idx_i == CFG_IDX_WIDTH)) begin
      width_d = width_cl[DimW-1:0];
    end
    if (cfg_we_i && (cfg_idx_i == CFG_IDX_HEIGHT)) begin
      height_d = height_cl[DimHW-1:0];
    end
  end

  // Stream position counters.
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pending_d = pending_q;
    priority if (restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      pending_d = '0;
    end else begin
      if (step) begin
        if (in_col_last) begin
          in_col_d = '0;
          if (pix_step) begin
            in_row_d = in_row_q + DimHW'(1);
          end
        end else begin
          in_col_d = in_col_q + ColW'(1);
        end
      end
      if (emit) begin
        if (out_col_last) begin
          out_col_d = '0;
          out_row_d = out_row_q + DimHW'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
      end
      if (pix_step && !emit) begin
        pending_d = pending_q + PendW'(1);
      end else if (drn_step) begin
        pending_d = pending_q - PendW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DimW'(2);
      height_q  <= DimHW'(2);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      pending_q <= '0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      pending_q <= pending_d;
    end
  end

  // The line memory is always read at the column of the next request, so the
  // entry is ready when that request arrives. A pixel rewrites its column with
  // itself and the foreground flag of the pixel it replaces, which is the row
  // above it.
  assign wr_ent.prev_fg = (rd_ent.value == FG_VALUE);
  assign wr_ent.value   = s_axis_tdata;

  bnc_ram #(
    .Width ($bits(line_ent_t)),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (pix_step),
    .waddr_i (in_col_q),
    .wdata_i (wr_ent),
    .raddr_i (in_col_d),
    .rdata_o (rd_ent)
  );

  // The incoming column is the right-hand column of the result's window; the
  // row below only exists while pixels still arrive.
  assign ncol.top = rd_ent.prev_fg;
  assign ncol.mid = rd_ent.value;
  assign ncol.bot = pix_step && (s_axis_tdata == FG_VALUE);

  assign mask.top   = (out_row_q != '0);
  assign mask.bot   = !out_row_last;
  assign mask.left  = (out_col_q != '0);
  assign mask.right = !out_col_last;

  bnc_window u_window (
    .clk_i   (clk_i),
    .shift_i (step),
    .ncol_i  (ncol),
    .mask_i  (mask),
    .value_o (res.value)
  );

  assign res.last = out_last;

  bnc_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (emit),
    .push_data_i   (res),
    .full_o        (buf_full),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // The backlog never exceeds one row plus one pixel.
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (DimW+1)'(pending_q) <= ((DimW+1)'(width_q) + (DimW+1)'(1)))
    else $error("pending result count exceeds width plus one");

  // Both column counters stay inside the current row.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (DimW'(in_col_q) < width_q) && (DimW'(out_col_q) < width_q))
    else $error("column counter outside the image row");

  // The final result of a frame returns the block to the start of a frame.
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_last) |=> (pending_q == '0) && (in_row_q == '0) &&
                           (out_row_q == '0) && (out_col_q == '0))
    else $error("stream did not restart after the last result of a frame");

  // A result is never produced while the output buffer is full.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !buf_full)
    else $error("result produced into a full output buffer");

endmodule

[bench/bnc_bench_pkg.sv]
// Result predictor and checker for the binary 3x3 neighbor count bench.
`timescale 1ns / 100ps
package bnc_bench_pkg;
  import bnc_pkg::*;

  class count_checker;
    int unsigned width;
    int unsigned height;
    logic [PIX_W-1:0] line_rows [0:3][0:MAX_WIDTH_DEF-1];
    int unsigned in_col;
    int unsigned in_row;
    int unsigned res_col;
    int unsigned res_row;
    int unsigned pending;
    res_t due_results[$];
    int unsigned errors;

    function new();
      width = 2;
      height = 2;
      errors = 0;
      restart();
    endfunction

    function void restart();
      in_col = 0;
      in_row = 0;
      res_col = 0;
      res_row = 0;
      pending = 0;
    endfunction

    function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned top);
      if (v < 2) return 2;
      if (v > top) return top;
      return 32'(v);
    endfunction

    // Any write to a known register restarts the stream.
    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_IDX_WIDTH) begin
        width = clamp_dim(val, MAX_WIDTH_DEF);
        restart();
      end else if (idx == CFG_IDX_HEIGHT) begin
        height = clamp_dim(val, MAX_HEIGHT_DEF);
        restart();
      end
    endfunction

    // Works out the result for the oldest pixel still in flight.
    function void predict_count();
      int r;
      int c;
      int rr;
      int cc;
      int dr;
      int dc;
      int unsigned cnt;
      logic [PIX_W-1:0] center;
      res_t res;
      r = res_row;
      c = res_col;
      center = line_rows[r % 4][c];
      res.value = center;
      if (center == FG_VALUE) begin
        cnt = 0;
        for (dr = -1; dr <= 1; dr++) begin
          for (dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if (dr == 0 && dc == 0) continue;
            if (rr < 0 || rr >= int'(height) || cc < 0 || cc >= int'(width)) continue;
            if (line_rows[rr % 4][cc] == FG_VALUE) cnt++;
          end
        end
        if (cnt != 0) res.value = cnt[PIX_W-1:0];
      end
      res.last = (r == int'(height) - 1) && (c == int'(width) - 1);
      due_results.push_back(res);
      if (pending > 0) pending--;
      if (res.last) begin
        restart();
      end else begin
        res_col++;
        if (res_col >= width) begin
          res_col = 0;
          res_row++;
        end
      end
    endfunction

    function void take_request(logic kind, logic [PIX_W-1:0] pix);
      bit frame_in;
      frame_in = in_row >= height;
      if (kind == REQ_DRAIN) begin
        if (frame_in && pending > 0) predict_count();
        return;
      end
      if (frame_in) return;
      line_rows[in_row % 4][in_col] = pix;
      in_col++;
      if (in_col >= width) begin
        in_col = 0;
        in_row++;
      end
      pending++;
      if (pending > width + 1) predict_count();
    endfunction

    function void check_result(logic [PIX_W-1:0] value, logic last);
      res_t exp_res;
      if (due_results.size() == 0) begin
        $error("unexpected result: out_value %0d, last_of_frame %0d", value, last);
        errors++;
        return;
      end
      exp_res = due_results.pop_front();
      if (value !== exp_res.value) begin
        $error("out_value: expected %0d, got %0d", exp_res.value, value);
        errors++;
      end
      if (last !== exp_res.last) begin
        $error("last_of_frame: expected %0d, got %0d", exp_res.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

[bench/tb.sv]
// Top of the bench: drives pixel and drain requests into the block and checks its results.
`timescale 1ns / 100ps
module tb;
  import bnc_pkg::*;
  import bnc_bench_pkg::*;

  localparam int unsigned LIMIT       = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 40;
  localparam int unsigned SETTLE_CYCLES = 8;
  // Pixels sent into the long frames of the oversized phases.
  localparam int unsigned WIDE_PIXELS = 1040;
  localparam int unsigned TALL_PIXELS = 60;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [PIX_W-1:0]     s_axis_tdata = '0;   // [7:0] pixel_value
  logic                 s_axis_tuser = 1'b0; // [0] req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [PIX_W-1:0]     m_axis_tdata;        // [7:0] out_value
  logic                 m_axis_tlast;        // last_of_frame

  count_checker board;

  // Idle percentages for the current phase; the long hold-off is requested by
  // bumping hold_requests and is then counted down by the receiver alone.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycles;

  always #5 clk_i = ~clk_i;

  binary_neighbor_count_3x3_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Every handshake is sampled at the rising edge, before any of this edge's
  // nonblocking updates land. A result seen now stems from an earlier request,
  // so it is checked before this edge's request is predicted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tlast);
      if (cfg_we_i) board.apply_write(cfg_idx_i, cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready) board.take_request(s_axis_tuser, s_axis_tdata);
    end
  end

  // Receiver: random stalls, or a long hold-off when one has been requested.
  always @(posedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: a hung block ends the run here.
  initial begin
    for (cycles = 0; cycles < LIMIT; cycles++) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  // Offers one request and returns at the edge that accepts it. The sender
  // may first go idle for a random number of cycles. Between requests the
  // valid line is either kept high or lowered, never both in one step.
  task automatic send_request(input logic kind, input logic [PIX_W-1:0] pix);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Stops offering requests and waits until every predicted result is back,
  // then keeps waiting so that any stray result has time to show.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends one frame at the current dimensions. A complete frame is followed
  // by exactly enough drain requests to flush it; an incomplete one stops
  // after a random number of pixels and is left for the next write to abandon.
  // Stray drains before the last pixel, a stray pixel after it and a stray
  // drain after the flush are mixed in now and then; the block ignores them.
  task automatic send_frame(input bit complete);
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned density;
    int unsigned i;
    logic [PIX_W-1:0] pix;
    w = board.width;
    h = board.height;
    n = complete ? w * h : $urandom_range(w * h, 0);
    density = $urandom_range(95, 10);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) send_request(REQ_DRAIN, PIX_W'($urandom));
      if ($urandom_range(99) < 8) pix = PIX_W'($urandom_range(255));
      else pix = ($urandom_range(99) < density) ? FG_VALUE : '0;
      send_request(REQ_PIXEL, pix);
    end
    if (complete) begin
      if ($urandom_range(99) < 15) send_request(REQ_PIXEL, PIX_W'($urandom));
      repeat (w + 1) send_request(REQ_DRAIN, PIX_W'($urandom));
      if ($urandom_range(99) < 10) send_request(REQ_DRAIN, PIX_W'($urandom));
    end
  endtask

  // Sends the first n pixels of a frame with no drains; the next write
  // abandons the rest of it.
  task automatic send_pixels(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      send_request(REQ_PIXEL, ($urandom_range(99) < 50) ? FG_VALUE : PIX_W'($urandom_range(2)));
    end
  endtask

  initial begin
    int unsigned p;
    int unsigned count;
    logic [CFG_W-1:0] w_val;
    logic [CFG_W-1:0] h_val;
    board = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset dimensions 2x2. A drain with nothing pending is
    // ignored. The all-ones frame gives three neighbors per pixel; it carries
    // a drain before its last pixel, a pixel after its last pixel and a drain
    // after its flush, all of which must produce nothing.
    send_request(REQ_DRAIN, 8'h00);
    send_request(REQ_PIXEL, FG_VALUE);
    send_request(REQ_PIXEL, FG_VALUE);
    send_request(REQ_DRAIN, 8'hFF);
    send_request(REQ_PIXEL, FG_VALUE);
    send_request(REQ_PIXEL, FG_VALUE);
    send_request(REQ_PIXEL, FG_VALUE);
    repeat (3) send_request(REQ_DRAIN, 8'h00);
    send_request(REQ_DRAIN, 8'h00);
    settle();

    // Dimensions below the minimum clamp to 2, unknown indexes do nothing,
    // then a 3x3 all-ones frame puts eight neighbors around its center.
    write_reg(CFG_IDX_WIDTH, 11'd0);
    write_reg(CFG_IDX_HEIGHT, 11'd1);
    write_reg(CFG_IDX_SPARE_A, 11'h7FF);
    write_reg(CFG_IDX_SPARE_B, 11'h555);
    write_reg(CFG_IDX_WIDTH, 11'd3);
    write_reg(CFG_IDX_HEIGHT, 11'd3);
    repeat (9) send_request(REQ_PIXEL, FG_VALUE);
    repeat (4) send_request(REQ_DRAIN, 8'h00);

    // Random part. Each phase picks an idle pattern and new dimensions; a few
    // phases use the extremes, including values above the maximum.
    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      case (p)
        2: begin w_val = 11'd2047; h_val = 11'd2;    end
        5: begin w_val = 11'd2;    h_val = 11'd1030; end
        8: begin w_val = 11'd1;    h_val = 11'd0;    end
        default: begin
          w_val = CFG_W'($urandom_range(12, 2));
          h_val = CFG_W'($urandom_range(8, 2));
        end
      endcase
      write_reg(CFG_IDX_WIDTH, w_val);
      write_reg(CFG_IDX_HEIGHT, h_val);

      // The receiver holds off for a long stretch while requests keep coming,
      // so the output buffer fills and the block stalls its input.
      if (p == 1) hold_requests++;

      if (p == 2 || p == 5) begin
        // Oversized dimensions clamp to the maximum. The wide frame runs past
        // its first full row, so the clamped row length shows in the results.
        send_pixels((p == 2) ? WIDE_PIXELS : TALL_PIXELS);
      end else begin
        count = 0;
        while (count < PHASE_ITEMS) begin
          send_frame(1'b1);
          count += board.width * board.height + board.width + 1;
          // In phase 3 only, the sender waits for every outstanding result between frames.
          if (p == 3 && count < PHASE_ITEMS) settle();
        end
        if ($urandom_range(1) == 1) send_frame(1'b0);
      end
    end

    settle();
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
